// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the xxHash64 block.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/xxh_pkg.sv =====
// Package of the xxHash64 block: primes, job record and small helpers.
// No dependencies; used by the front, queue, back and top level.
package xxh_pkg;

  localparam logic [63:0] P1 = 64'h9E3779B185EBCA87;
  localparam logic [63:0] P2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] P3 = 64'h165667B19E3779F9;
  localparam logic [63:0] P4 = 64'h85EBCA77C2B2AE63;
  localparam logic [63:0] P5 = 64'h27D4EB2F165667C5;

  // One unit of work for the back part: an optional full stripe and an
  // optional end of message with the tail bytes that remain.
  typedef struct packed {
    logic         has_stripe;
    logic         is_last;
    logic [255:0] stripe;
    logic [255:0] tail;
    logic [4:0]   rem;
    logic [63:0]  length;
  } job_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned r);
    rotl = (x << r) | (x >> (64 - r));
  endfunction

  function automatic logic [63:0] lane_init(input logic [63:0] s, input logic [1:0] i);
    logic [63:0] v;
    case (i)
      2'd0:    v = s + P1 + P2;
      2'd1:    v = s + P2;
      2'd2:    v = s;
      default: v = s - P1;
    endcase
    lane_init = v;
  endfunction

endpackage

// ===== rtl/xxh_front.sv =====
// Front part: accepts message items, packs bytes into the stripe buffer and
// forms jobs for the back part. Depends on xxh_pkg.
module xxh_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [63:0]       data_word,
  input  logic [3:0]        byte_count,
  input  logic              last,
  input  logic              restart,
  output logic              push,
  output xxh_pkg::job_t     job
);

  logic [7:0]  stripe_buf [32];
  logic [4:0]  fill;
  logic [63:0] len;

  logic [3:0]  cnt;
  logic [5:0]  sum;
  logic [7:0]  merged [32];
  logic [255:0] stripe_flat;
  logic [255:0] tail_flat;

  always_comb begin
    logic [4:0]  idx;
    logic        take;
    logic [63:0] sh;
    cnt = (byte_count > 4'd8) ? 4'd8 : byte_count;
    sum = {1'b0, fill} + {2'b00, cnt};
    for (int k = 0; k < 32; k++) begin
      idx  = 5'(k) - fill;
      take = idx < {1'b0, cnt};
      sh   = data_word >> {idx[2:0], 3'b000};
      merged[k] = take ? sh[7:0] : stripe_buf[k];
      // A byte that wrapped to the buffer start belongs to the next stripe.
      stripe_flat[8*k +: 8] = (take && (5'(k) >= fill)) ? sh[7:0] : stripe_buf[k];
      tail_flat[8*k +: 8]   = merged[k];
    end
  end

  assign push = accept && (sum[5] || last);

  always_comb begin
    job.has_stripe = sum[5];
    job.is_last    = last;
    job.stripe     = stripe_flat;
    job.tail       = tail_flat;
    job.rem        = sum[4:0];
    job.length     = len + {60'd0, cnt};
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < 32; k++) begin
        stripe_buf[k] <= merged[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      fill <= '0;
      len  <= '0;
    end else if (accept) begin
      fill <= last ? 5'd0 : sum[4:0];
      len  <= last ? 64'd0 : len + {60'd0, cnt};
    end
  end

endmodule

// ===== rtl/xxh_fifo.sv =====
// Two-entry job queue between the front and back parts.
// Depends on xxh_pkg for the job record.
module xxh_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  xxh_pkg::job_t wdata,
  input  logic          pop,
  output xxh_pkg::job_t rdata,
  output logic          full,
  output logic          empty
);

  xxh_pkg::job_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full  = count == 2'd2;
  assign empty = count == 2'd0;
  assign rdata = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/xxh_mul.sv =====
// 64x64 multiplier, low 64 bits of the product, built from one 32x32
// multiplier that adds the low-low, low-high and high-low partial products in turn.
module xxh_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] result
);

  logic [1:0]  ph;
  logic [63:0] acc;
  logic [31:0] ma;
  logic [31:0] mb;
  logic [63:0] p;

  assign ma     = (ph == 2'd2) ? a[63:32] : a[31:0];
  assign mb     = (ph == 2'd1) ? b[63:32] : b[31:0];
  assign p      = {32'd0, ma} * {32'd0, mb};
  assign done   = go && (ph == 2'd3);
  assign result = acc;

  always_ff @(posedge clk) begin
    if (go) begin
      if (ph == 2'd0) acc <= p;
      else if (ph != 2'd3) acc <= acc + {p[31:0], 32'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) ph <= '0;
    else if (go) ph <= ph + 2'd1;
  end

endmodule

// ===== rtl/xxh_back.sv =====
// Back part: lane rounds for full stripes and the finishing sequence.
// Depends on xxh_pkg and xxh_mul.
module xxh_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [63:0]   cfg_data,
  input  logic          q_empty,
  input  xxh_pkg::job_t q_data,
  output logic          q_pop,
  input  logic          out_stall,
  output logic          out_valid,
  output logic [63:0]   hash
);

  typedef enum logic [18:0] {
    ST_IDLE    = 19'h00001,
    ST_LANE_A  = 19'h00002,
    ST_LANE_B  = 19'h00004,
    ST_FIN     = 19'h00008,
    ST_MERGE_A = 19'h00010,
    ST_MERGE_B = 19'h00020,
    ST_MERGE_C = 19'h00040,
    ST_ADDLEN  = 19'h00080,
    ST_TAIL    = 19'h00100,
    ST_T8_A    = 19'h00200,
    ST_T8_B    = 19'h00400,
    ST_T8_C    = 19'h00800,
    ST_T4_A    = 19'h01000,
    ST_T4_B    = 19'h02000,
    ST_T1_A    = 19'h04000,
    ST_T1_B    = 19'h08000,
    ST_AV_A    = 19'h10000,
    ST_AV_B    = 19'h20000,
    ST_OUT     = 19'h40000
  } state_t;

  state_t        state;
  xxh_pkg::job_t job;
  logic [63:0]   seed;
  logic [63:0]   lanes [4];
  logic [63:0]   h;
  logic [63:0]   t;
  logic [1:0]    idx;
  logic [4:0]    pos;
  logic [4:0]    rem;

  logic          mul_go;
  logic          mul_done;
  logic [63:0]   mul_a;
  logic [63:0]   mul_b;
  logic [63:0]   res;
  logic [255:0]  stripe_sh;
  logic [255:0]  tail_sh;
  logic          load_out;

  assign stripe_sh = job.stripe >> {idx, 6'd0};
  assign tail_sh   = job.tail >> {pos, 3'd0};
  assign q_pop     = (state == ST_IDLE) && !q_empty;
  assign load_out  = (state == ST_OUT) && (!out_valid || !out_stall);

  always_comb begin
    mul_go = 1'b1;
    mul_a  = '0;
    mul_b  = xxh_pkg::P1;
    case (state)
      ST_LANE_A:  begin mul_a = stripe_sh[63:0]; mul_b = xxh_pkg::P2; end
      ST_LANE_B:  mul_a = xxh_pkg::rotl(lanes[idx] + t, 31);
      ST_MERGE_A: begin mul_a = lanes[idx]; mul_b = xxh_pkg::P2; end
      ST_MERGE_B: mul_a = xxh_pkg::rotl(t, 31);
      ST_MERGE_C: mul_a = h ^ t;
      ST_T8_A:    begin mul_a = tail_sh[63:0]; mul_b = xxh_pkg::P2; end
      ST_T8_B:    mul_a = xxh_pkg::rotl(t, 31);
      ST_T8_C:    mul_a = xxh_pkg::rotl(h ^ t, 27);
      ST_T4_A:    mul_a = {32'd0, tail_sh[31:0]};
      ST_T4_B:    begin mul_a = xxh_pkg::rotl(h ^ t, 23); mul_b = xxh_pkg::P2; end
      ST_T1_A:    begin mul_a = {56'd0, tail_sh[7:0]}; mul_b = xxh_pkg::P5; end
      ST_T1_B:    mul_a = xxh_pkg::rotl(h ^ t, 11);
      ST_AV_A:    begin mul_a = h ^ (h >> 33); mul_b = xxh_pkg::P2; end
      ST_AV_B:    begin mul_a = h ^ (h >> 29); mul_b = xxh_pkg::P3; end
      default:    mul_go = 1'b0;
    endcase
  end

  xxh_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .go     (mul_go),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= '0;
      for (int i = 0; i < 4; i++) lanes[i] <= xxh_pkg::lane_init(64'd0, 2'(i));
    end else if (cfg_we) begin
      seed <= cfg_data;
      for (int i = 0; i < 4; i++) lanes[i] <= xxh_pkg::lane_init(cfg_data, 2'(i));
    end else if (load_out) begin
      for (int i = 0; i < 4; i++) lanes[i] <= xxh_pkg::lane_init(seed, 2'(i));
    end else if ((state == ST_LANE_B) && mul_done) begin
      lanes[idx] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) hash <= h ^ (h >> 32);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            job   <= q_data;
            idx   <= '0;
            state <= q_data.has_stripe ? ST_LANE_A : ST_FIN;
          end
        end
        ST_LANE_A: if (mul_done) begin t <= res; state <= ST_LANE_B; end
        ST_LANE_B: begin
          if (mul_done) begin
            idx <= idx + 2'd1;
            if (idx == 2'd3) state <= job.is_last ? ST_FIN : ST_IDLE;
            else state <= ST_LANE_A;
          end
        end
        ST_FIN: begin
          idx <= '0;
          if (job.length[63:5] != '0) begin
            h <= xxh_pkg::rotl(lanes[0], 1) + xxh_pkg::rotl(lanes[1], 7)
               + xxh_pkg::rotl(lanes[2], 12) + xxh_pkg::rotl(lanes[3], 18);
            state <= ST_MERGE_A;
          end else begin
            h     <= seed + xxh_pkg::P5;
            state <= ST_ADDLEN;
          end
        end
        ST_MERGE_A: if (mul_done) begin t <= res; state <= ST_MERGE_B; end
        ST_MERGE_B: if (mul_done) begin t <= res; state <= ST_MERGE_C; end
        ST_MERGE_C: begin
          if (mul_done) begin
            h   <= res + xxh_pkg::P4;
            idx <= idx + 2'd1;
            state <= (idx == 2'd3) ? ST_ADDLEN : ST_MERGE_A;
          end
        end
        ST_ADDLEN: begin
          h     <= h + job.length;
          pos   <= '0;
          rem   <= job.rem;
          state <= ST_TAIL;
        end
        ST_TAIL: begin
          if (rem >= 5'd8) state <= ST_T8_A;
          else if (rem >= 5'd4) state <= ST_T4_A;
          else if (rem != 5'd0) state <= ST_T1_A;
          else state <= ST_AV_A;
        end
        ST_T8_A: if (mul_done) begin t <= res; state <= ST_T8_B; end
        ST_T8_B: if (mul_done) begin t <= res; state <= ST_T8_C; end
        ST_T8_C: begin
          if (mul_done) begin
            h     <= res + xxh_pkg::P4;
            pos   <= pos + 5'd8;
            rem   <= rem - 5'd8;
            state <= ST_TAIL;
          end
        end
        ST_T4_A: if (mul_done) begin t <= res; state <= ST_T4_B; end
        ST_T4_B: begin
          if (mul_done) begin
            h     <= res + xxh_pkg::P3;
            pos   <= pos + 5'd4;
            rem   <= rem - 5'd4;
            state <= ST_TAIL;
          end
        end
        ST_T1_A: if (mul_done) begin t <= res; state <= ST_T1_B; end
        ST_T1_B: begin
          if (mul_done) begin
            h     <= res;
            pos   <= pos + 5'd1;
            rem   <= rem - 5'd1;
            state <= ST_TAIL;
          end
        end
        ST_AV_A: if (mul_done) begin h <= res; state <= ST_AV_B; end
        ST_AV_B: if (mul_done) begin h <= res; state <= ST_OUT; end
        ST_OUT:  if (load_out) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/xxh64_streaming_hash.sv =====
// A full stripe costs eight 64-bit multiplies in the back part, all on the
// one shared 32x32 multiplier, which also serves the finishing sequence.
// The front part keeps taking items while the back part works, until the job queue fills.
// Reset (rst, synchronous): seed 0, lanes from seed, queue and counts cleared.
module xxh64_streaming_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] seed,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] data_word,
  input  logic [3:0]  byte_count,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] hash
);

`include "assert_macros.svh"

  // The seed register is always writable; writes are expected only while
  // the block is idle, and each one restarts the message state.
  logic          cfg_we;
  logic          in_accept;
  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  xxh_pkg::job_t q_wdata;
  xxh_pkg::job_t q_rdata;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid;

  // The front part stalls whenever the job queue is full, even for a transfer
  // that only adds bytes to the stripe buffer and pushes no job.
  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  xxh_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_accept),
    .data_word  (data_word),
    .byte_count (byte_count),
    .last       (last),
    .restart    (cfg_we),
    .push       (q_push),
    .job        (q_wdata)
  );

  // Each job holds a full stripe, the end of a message, or both.
  xxh_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // The back part holds the lane accumulators and the seed, and owns the
  // output register that parts it from the consumer.
  xxh_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (seed),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .hash      (hash)
  );

  `ASSERT_SAME(a_no_overflow, clk, rst, q_push, !q_full, "job pushed into a full queue")
  `ASSERT_SAME(a_no_underflow, clk, rst, q_pop, !q_empty, "job popped from an empty queue")

endmodule
